@@ rtl/grid_heightmap_triangulator_defines.svh @@
// Assertion macros used by the triangulator RTL.
`ifndef GRID_HEIGHTMAP_TRIANGULATOR_DEFINES_SVH
`define GRID_HEIGHTMAP_TRIANGULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define GHT_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHT_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`else

`define GHT_ASSERT_NOW(label, clk, rstn, pre, post, msg)

`define GHT_ASSERT_NEXT(label, clk, rstn, pre, post, msg)

`endif

`endif

@@ rtl/ght_pkg.sv @@
package ght_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 4096;
    localparam int COORD_BITS_DEFAULT = 40;

    localparam int OUT_COORD_BITS = 40;
    localparam int ALT_BITS       = 32;
    localparam int STEP_BITS      = 24;
    localparam int GW_BITS        = 13;
    localparam int GH_BITS        = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 40;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_STEP_X      = 3'd2,
        REG_STEP_Y      = 3'd3,
        REG_GRID_WIDTH  = 3'd4,
        REG_GRID_HEIGHT = 3'd5,
        REG_NODATA      = 3'd6
    } cfg_reg_t;

    localparam logic [STEP_BITS-1:0]       STEP_RESET   = 24'd256;
    localparam logic [GW_BITS-1:0]         GW_RESET     = 13'd2;
    localparam logic [GH_BITS-1:0]         GH_RESET     = 16'd2;
    localparam logic signed [ALT_BITS-1:0] NODATA_RESET = -32'sd2559744;

    typedef struct packed {
        logic [OUT_COORD_BITS-1:0] a_x;
        logic [OUT_COORD_BITS-1:0] a_y;
        logic [ALT_BITS-1:0]       a_z;
        logic [OUT_COORD_BITS-1:0] b_x;
        logic [OUT_COORD_BITS-1:0] b_y;
        logic [ALT_BITS-1:0]       b_z;
        logic [OUT_COORD_BITS-1:0] c_x;
        logic [OUT_COORD_BITS-1:0] c_y;
        logic [ALT_BITS-1:0]       c_z;
        logic                      lower;
        logic                      last;
    } tri_t;

endpackage

@@ rtl/grid_heightmap_triangulator.sv @@
// Grid heightmap triangulator. Altitude samples enter in raster order, top row first and
// west to east; each sample that closes a grid cell yields up to two triangles, one result
// request each, which pass from the triangle stage into the result register. A sample is
// taken in every cycle while m_ready does not stall the result register; a sample whose
// cell yields both triangles holds the triangle stage until both have entered the single
// result register. The previous row lives in a single-port line buffer that is read and
// rewritten at the same column when a sample is accepted. Writing any defined register
// restarts the grid at its top row and holds s_ready low for one cycle while the
// coordinate accumulators reload, as after reset. The line buffer needs no clearing pass.
`include "grid_heightmap_triangulator_defines.svh"

module grid_heightmap_triangulator #(
    parameter int MAX_WIDTH  = ght_pkg::MAX_WIDTH_DEFAULT,
    parameter int COORD_BITS = ght_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,

    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [ght_pkg::ALT_BITS-1:0]       s_altitude,

    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_a_x,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_a_y,
    output logic signed [ght_pkg::ALT_BITS-1:0]       m_vertex_a_z,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_b_x,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_b_y,
    output logic signed [ght_pkg::ALT_BITS-1:0]       m_vertex_b_z,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_c_x,
    output logic signed [ght_pkg::OUT_COORD_BITS-1:0] m_vertex_c_y,
    output logic signed [ght_pkg::ALT_BITS-1:0]       m_vertex_c_z,
    output logic                                      m_lower_triangle,
    output logic                                      m_last_of_cell,

    input  logic                                      cfg_wr_en,
    input  logic [ght_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [ght_pkg::CFG_DATA_BITS-1:0]         cfg_wr_data
);

    import ght_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int WB_RAW    = $clog2(MAX_WIDTH + 1);
    localparam int WB        = (WB_RAW > GW_BITS) ? WB_RAW : GW_BITS;
    localparam int HB        = GH_BITS + 1;

    // Configuration registers.
    logic [OUT_COORD_BITS-1:0] origin_x_reg;
    logic [OUT_COORD_BITS-1:0] origin_y_reg;
    logic [STEP_BITS-1:0]      step_x_reg;
    logic [STEP_BITS-1:0]      step_y_reg;
    logic [GW_BITS-1:0]        grid_width_reg;
    logic [GH_BITS-1:0]        grid_height_reg;
    logic [ALT_BITS-1:0]       nodata_reg;
    logic                      restart_reg;

    // Scan state.
    logic [ADDR_BITS-1:0]      col_reg;
    logic [GH_BITS-1:0]        row_reg;
    logic [COORD_BITS-1:0]     x_acc_reg;
    logic [COORD_BITS-1:0]     y_acc_reg;
    logic [ALT_BITS-1:0]       left_reg;

    // Triangle stage.
    logic                      s1_valid_reg;
    logic                      s1_done1_reg;
    logic                      s1_inner_reg;
    logic [ALT_BITS-1:0]       s1_ul_reg;
    logic [ALT_BITS-1:0]       s1_ll_reg;
    logic [ALT_BITS-1:0]       s1_lr_reg;
    logic [COORD_BITS-1:0]     s1_xmax_reg;
    logic [COORD_BITS-1:0]     s1_ymin_reg;

    // Result register.
    logic                      m_valid_reg;
    tri_t                      m_tri_reg;
    tri_t                      tri_next;

    logic [WB-1:0]             gw_ext;
    logic [WB-1:0]             eff_w;
    logic [WB-1:0]             col_ext;
    logic [GH_BITS-1:0]        eff_h;
    logic [GH_BITS+STEP_BITS-1:0] y_span;
    logic [COORD_BITS-1:0]     x_origin;
    logic [COORD_BITS-1:0]     y_top;
    logic                      col_last;
    logic                      row_last;
    logic                      s_accept;

    logic [ALT_BITS-1:0]       ur;
    logic [COORD_BITS-1:0]     xmin;
    logic [COORD_BITS-1:0]     ymax;
    logic                      emit1;
    logic                      emit2;
    logic                      send1;
    logic                      has_out;
    logic                      send_last;
    logic                      out_load;
    logic                      s1_release;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            step_x_reg      <= STEP_RESET;
            step_y_reg      <= STEP_RESET;
            grid_width_reg  <= GW_RESET;
            grid_height_reg <= GH_RESET;
            nodata_reg      <= NODATA_RESET;
            restart_reg     <= 1'b1;
        end else begin
            restart_reg <= 1'b0;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X: begin
                        origin_x_reg <= cfg_wr_data[OUT_COORD_BITS-1:0];
                        restart_reg  <= 1'b1;
                    end
                    REG_ORIGIN_Y: begin
                        origin_y_reg <= cfg_wr_data[OUT_COORD_BITS-1:0];
                        restart_reg  <= 1'b1;
                    end
                    REG_STEP_X: begin
                        step_x_reg  <= cfg_wr_data[STEP_BITS-1:0];
                        restart_reg <= 1'b1;
                    end
                    REG_STEP_Y: begin
                        step_y_reg  <= cfg_wr_data[STEP_BITS-1:0];
                        restart_reg <= 1'b1;
                    end
                    REG_GRID_WIDTH: begin
                        grid_width_reg <= cfg_wr_data[GW_BITS-1:0];
                        restart_reg    <= 1'b1;
                    end
                    REG_GRID_HEIGHT: begin
                        grid_height_reg <= cfg_wr_data[GH_BITS-1:0];
                        restart_reg     <= 1'b1;
                    end
                    REG_NODATA: begin
                        nodata_reg  <= cfg_wr_data[ALT_BITS-1:0];
                        restart_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Effective grid size, clamped to the supported range.
    always_comb begin
        gw_ext = WB'(grid_width_reg);
        if (gw_ext < WB'(2)) begin
            eff_w = WB'(2);
        end else if (gw_ext > WB'(MAX_WIDTH)) begin
            eff_w = WB'(MAX_WIDTH);
        end else begin
            eff_w = gw_ext;
        end
    end

    assign eff_h    = (grid_height_reg < GH_BITS'(2)) ? GH_BITS'(2) : grid_height_reg;
    assign y_span   = (eff_h - GH_BITS'(1)) * step_y_reg;
    assign x_origin = COORD_BITS'($signed(origin_x_reg));
    assign y_top    = COORD_BITS'($signed(origin_y_reg)) + COORD_BITS'(y_span);

    assign col_ext  = WB'(col_reg);
    assign col_last = (col_ext + WB'(1)) >= eff_w;
    assign row_last = ({1'b0, row_reg} + HB'(1)) >= {1'b0, eff_h};
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
            left_reg  <= '0;
        end else if (restart_reg) begin
            col_reg   <= '0;
            row_reg   <= '0;
            x_acc_reg <= x_origin;
            y_acc_reg <= y_top;
        end else if (s_accept) begin
            left_reg <= s_altitude;
            if (col_last) begin
                col_reg   <= '0;
                x_acc_reg <= x_origin;
                if (row_last) begin
                    row_reg   <= '0;
                    y_acc_reg <= y_top;
                end else begin
                    row_reg   <= row_reg + GH_BITS'(1);
                    y_acc_reg <= y_acc_reg - COORD_BITS'(step_y_reg);
                end
            end else begin
                col_reg   <= col_reg + ADDR_BITS'(1);
                x_acc_reg <= x_acc_reg + COORD_BITS'(step_x_reg);
            end
        end
    end

    // The entry at the current column still holds the row above when it is read,
    // and takes the new sample in the same access.
    ght_ram #(
        .WIDTH (ALT_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (aclk),
        .en    (s_accept),
        .we    (s_accept),
        .addr  (col_reg),
        .wdata (s_altitude),
        .rdata (ur)
    );

    // The upper-left corner is the upper-right corner of the previous sample, which
    // the buffer output still holds when the next sample is accepted.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_inner_reg <= (row_reg != '0) && (col_reg != '0);
            s1_ul_reg    <= ur;
            s1_ll_reg    <= left_reg;
            s1_lr_reg    <= s_altitude;
            s1_xmax_reg  <= x_acc_reg;
            s1_ymin_reg  <= y_acc_reg;
        end
    end

    assign xmin  = s1_xmax_reg - COORD_BITS'(step_x_reg);
    assign ymax  = s1_ymin_reg + COORD_BITS'(step_y_reg);
    assign emit1 = s1_inner_reg && (s1_ul_reg != nodata_reg) && (s1_ll_reg != nodata_reg)
                   && (ur != nodata_reg);
    assign emit2 = s1_inner_reg && (ur != nodata_reg) && (s1_ll_reg != nodata_reg)
                   && (s1_lr_reg != nodata_reg);

    assign send1      = emit1 && !s1_done1_reg;
    assign has_out    = s1_valid_reg && (send1 || emit2);
    assign send_last  = !send1 || !emit2;
    assign out_load   = has_out && (!m_valid_reg || m_ready);
    assign s1_release = s1_valid_reg && (!(send1 || emit2) || (out_load && send_last));
    assign s_ready    = !restart_reg && (!s1_valid_reg || s1_release);

    always_comb begin
        tri_next = '0;
        if (send1) begin
            tri_next.a_x   = OUT_COORD_BITS'(xmin);
            tri_next.a_y   = OUT_COORD_BITS'(ymax);
            tri_next.a_z   = s1_ul_reg;
            tri_next.b_x   = OUT_COORD_BITS'(xmin);
            tri_next.b_y   = OUT_COORD_BITS'(s1_ymin_reg);
            tri_next.b_z   = s1_ll_reg;
            tri_next.c_x   = OUT_COORD_BITS'(s1_xmax_reg);
            tri_next.c_y   = OUT_COORD_BITS'(ymax);
            tri_next.c_z   = ur;
            tri_next.lower = 1'b0;
            tri_next.last  = !emit2;
        end else begin
            tri_next.a_x   = OUT_COORD_BITS'(s1_xmax_reg);
            tri_next.a_y   = OUT_COORD_BITS'(ymax);
            tri_next.a_z   = ur;
            tri_next.b_x   = OUT_COORD_BITS'(xmin);
            tri_next.b_y   = OUT_COORD_BITS'(s1_ymin_reg);
            tri_next.b_z   = s1_ll_reg;
            tri_next.c_x   = OUT_COORD_BITS'(s1_xmax_reg);
            tri_next.c_y   = OUT_COORD_BITS'(s1_ymin_reg);
            tri_next.c_z   = s1_lr_reg;
            tri_next.lower = 1'b1;
            tri_next.last  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_done1_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            s1_done1_reg <= 1'b0;
        end else if (s1_release) begin
            s1_valid_reg <= 1'b0;
            s1_done1_reg <= 1'b0;
        end else if (out_load) begin
            // The first triangle left; the second one follows.
            s1_done1_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tri_reg <= tri_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_vertex_a_x     = $signed(m_tri_reg.a_x);
    assign m_vertex_a_y     = $signed(m_tri_reg.a_y);
    assign m_vertex_a_z     = $signed(m_tri_reg.a_z);
    assign m_vertex_b_x     = $signed(m_tri_reg.b_x);
    assign m_vertex_b_y     = $signed(m_tri_reg.b_y);
    assign m_vertex_b_z     = $signed(m_tri_reg.b_z);
    assign m_vertex_c_x     = $signed(m_tri_reg.c_x);
    assign m_vertex_c_y     = $signed(m_tri_reg.c_y);
    assign m_vertex_c_z     = $signed(m_tri_reg.c_z);
    assign m_lower_triangle = m_tri_reg.lower;
    assign m_last_of_cell   = m_tri_reg.last;

    `GHT_ASSERT_NOW(a_restart_blocks_input, aclk, aresetn, restart_reg, !s_ready, "sample accepted during restart")
    `GHT_ASSERT_NEXT(a_restart_clears_scan, aclk, aresetn, restart_reg, (col_reg == '0) && (row_reg == '0), "restart did not clear the scan position")
    `GHT_ASSERT_NOW(a_col_in_range, aclk, aresetn, !restart_reg, col_ext < eff_w, "column position beyond grid width")
    `GHT_ASSERT_NOW(a_second_pending, aclk, aresetn, s1_done1_reg, s1_valid_reg && emit2, "first triangle sent without a second one pending")

endmodule

@@ rtl/ght_ram.sv @@
module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a write returns the old contents of the addressed entry.
    always_ff @(posedge clk) begin
        if (en) begin
            rdata <= mem[addr];
            if (we) begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

@@ dv/grid_heightmap_triangulator_test.sv @@
module grid_heightmap_triangulator_test;

    import ght_pkg::*;

    localparam int LINE_DEPTH    = MAX_WIDTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 800;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    // Index 7 names no register; a write there must leave the grid alone.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

    localparam logic [OUT_COORD_BITS-1:0] Q8_ONE = 40'd256;

    typedef struct {
        logic [ALT_BITS-1:0] alt;
        bit                  typed;
        int                  count;
        tri_t                first;
        tri_t                second;
    } probe_t;

    typedef struct {
        logic [OUT_COORD_BITS-1:0] org_x;
        logic [OUT_COORD_BITS-1:0] org_y;
        logic [STEP_BITS-1:0]      spc_x;
        logic [STEP_BITS-1:0]      spc_y;
        logic [GW_BITS-1:0]        cols;
        logic [GH_BITS-1:0]        rows;
        logic [ALT_BITS-1:0]       missing;
        int                        items;
        bit                        calm;
        bit                        probe_unused;
    } grid_setup_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [ALT_BITS-1:0]       s_altitude = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_COORD_BITS-1:0] m_vertex_a_x, m_vertex_a_y;
    logic [ALT_BITS-1:0]       m_vertex_a_z;
    logic [OUT_COORD_BITS-1:0] m_vertex_b_x, m_vertex_b_y;
    logic [ALT_BITS-1:0]       m_vertex_b_z;
    logic [OUT_COORD_BITS-1:0] m_vertex_c_x, m_vertex_c_y;
    logic [ALT_BITS-1:0]       m_vertex_c_z;
    logic                      m_lower_triangle;
    logic                      m_last_of_cell;

    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;

    // Mirror of the block: registers and grid walk state.
    logic [OUT_COORD_BITS-1:0] org_x, org_y;
    logic [STEP_BITS-1:0]      spc_x, spc_y;
    logic [GW_BITS-1:0]        cols;
    logic [GH_BITS-1:0]        rows;
    logic [ALT_BITS-1:0]       nodata;
    logic [ALT_BITS-1:0]       line_mem [0:LINE_DEPTH-1];
    logic [ALT_BITS-1:0]       prev_alt;
    int unsigned               col_now, row_now;
    logic [OUT_COORD_BITS-1:0] x_now, y_now;

    tri_t        expected_tris [$];
    probe_t      probes [$];
    grid_setup_t fixed [$];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    grid_heightmap_triangulator DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_altitude       (s_altitude),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_vertex_a_x     (m_vertex_a_x),
        .m_vertex_a_y     (m_vertex_a_y),
        .m_vertex_a_z     (m_vertex_a_z),
        .m_vertex_b_x     (m_vertex_b_x),
        .m_vertex_b_y     (m_vertex_b_y),
        .m_vertex_b_z     (m_vertex_b_z),
        .m_vertex_c_x     (m_vertex_c_x),
        .m_vertex_c_y     (m_vertex_c_y),
        .m_vertex_c_z     (m_vertex_c_z),
        .m_lower_triangle (m_lower_triangle),
        .m_last_of_cell   (m_last_of_cell),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void add_probe(input probe_t p);
        probes = {probes, p};
    endfunction

    function automatic void add_setup(input grid_setup_t g);
        fixed = {fixed, g};
    endfunction

    function automatic tri_t make_tri(
        input logic [OUT_COORD_BITS-1:0] ax, input logic [OUT_COORD_BITS-1:0] ay,
        input logic [ALT_BITS-1:0] az,
        input logic [OUT_COORD_BITS-1:0] bx, input logic [OUT_COORD_BITS-1:0] by,
        input logic [ALT_BITS-1:0] bz,
        input logic [OUT_COORD_BITS-1:0] cx, input logic [OUT_COORD_BITS-1:0] cy,
        input logic [ALT_BITS-1:0] cz,
        input logic lower, input logic last);
        tri_t t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        t.lower = lower;
        t.last = last;
        return t;
    endfunction

    function automatic int unsigned used_cols();
        if (cols < 2) return 2;
        if (cols > LINE_DEPTH) return LINE_DEPTH;
        return cols;
    endfunction

    function automatic int unsigned used_rows();
        return (rows < 2) ? 2 : rows;
    endfunction

    function automatic void reload_top_y();
        logic [63:0] span;
        span = 64'(used_rows() - 1) * 64'(spc_y);
        y_now = org_y + span[OUT_COORD_BITS-1:0];
    endfunction

    function automatic void restart_grid();
        col_now = 0;
        row_now = 0;
        x_now = org_x;
        reload_top_y();
    endfunction

    function automatic void reset_mirror();
        org_x = '0;
        org_y = '0;
        spc_x = STEP_RESET;
        spc_y = STEP_RESET;
        cols = GW_RESET;
        rows = GH_RESET;
        nodata = NODATA_RESET;
        foreach (line_mem[i]) line_mem[i] = '0;
        prev_alt = '0;
        restart_grid();
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_ORIGIN_X:    org_x = data;
            REG_ORIGIN_Y:    org_y = data;
            REG_STEP_X:      spc_x = data[STEP_BITS-1:0];
            REG_STEP_Y:      spc_y = data[STEP_BITS-1:0];
            REG_GRID_WIDTH:  cols = data[GW_BITS-1:0];
            REG_GRID_HEIGHT: rows = data[GH_BITS-1:0];
            REG_NODATA:      nodata = data[ALT_BITS-1:0];
            default:         return;
        endcase
        restart_grid();
    endfunction

    // Walks one sample through the grid and returns the triangles of the cell it closes.
    function automatic void advance_grid(input logic [ALT_BITS-1:0] alt, output int n,
                                         output tri_t tris [2]);
        int unsigned               w, c;
        logic [ALT_BITS-1:0]       ul, ur, ll;
        logic [OUT_COORD_BITS-1:0] xmin, xmax, ymin, ymax;
        w = used_cols();
        c = (col_now >= w) ? w - 1 : col_now;
        n = 0;
        tris[0] = '0;
        tris[1] = '0;
        if (row_now > 0 && c > 0) begin
            ul = line_mem[c-1];
            ur = line_mem[c];
            ll = prev_alt;
            xmax = x_now;
            xmin = x_now - spc_x;
            ymin = y_now;
            ymax = y_now + spc_y;
            if (ul != nodata && ll != nodata && ur != nodata) begin
                tris[n] = make_tri(xmin, ymax, ul, xmin, ymin, ll, xmax, ymax, ur, 1'b0, 1'b0);
                n++;
            end
            if (ur != nodata && ll != nodata && alt != nodata) begin
                tris[n] = make_tri(xmax, ymax, ur, xmin, ymin, ll, xmax, ymin, alt, 1'b1, 1'b0);
                n++;
            end
            if (n > 0) tris[n-1].last = 1'b1;
        end
        // The upper-left entry is overwritten one column late, after it has been used.
        if (c > 0) line_mem[c-1] = prev_alt;
        prev_alt = alt;
        if (c + 1 >= w) begin
            line_mem[c] = alt;
            col_now = 0;
            x_now = org_x;
            row_now++;
            if (row_now >= used_rows()) begin
                row_now = 0;
                reload_top_y();
            end else begin
                y_now = y_now - spc_y;
            end
        end else begin
            col_now = c + 1;
            x_now = x_now + spc_x;
        end
    endfunction

    function automatic logic [ALT_BITS-1:0] pick_altitude();
        case ($urandom_range(7))
            0:       return nodata;
            1:       return ALT_BITS'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OUT_COORD_BITS-1:0] random_coord();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[OUT_COORD_BITS-1:0];
    endfunction

    function automatic grid_setup_t random_setup();
        grid_setup_t g;
        g.org_x = random_coord();
        g.org_y = random_coord();
        g.spc_x = ($urandom_range(7) == 0) ? '0 :
                  ($urandom_range(3) == 0) ? STEP_BITS'($urandom) :
                  STEP_BITS'($urandom_range(1, 1024));
        g.spc_y = ($urandom_range(7) == 0) ? '0 :
                  ($urandom_range(3) == 0) ? STEP_BITS'($urandom) :
                  STEP_BITS'($urandom_range(1, 1024));
        case ($urandom_range(9))
            0:       g.cols = GW_BITS'($urandom_range(1));
            1:       g.cols = GW_BITS'($urandom_range(10, 40));
            default: g.cols = GW_BITS'($urandom_range(2, 9));
        endcase
        g.rows = ($urandom_range(9) == 0) ? GH_BITS'($urandom) : GH_BITS'($urandom_range(0, 8));
        g.missing = $urandom;
        g.items = $urandom_range(30, 150);
        g.calm = 1'b0;
        g.probe_unused = 1'b0;
        return g;
    endfunction

    task automatic compare_field(input string name, input logic [OUT_COORD_BITS-1:0] want,
                                 input logic [OUT_COORD_BITS-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        tri_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = make_tri(m_vertex_a_x, m_vertex_a_y, m_vertex_a_z,
                           m_vertex_b_x, m_vertex_b_y, m_vertex_b_z,
                           m_vertex_c_x, m_vertex_c_y, m_vertex_c_z,
                           m_lower_triangle, m_last_of_cell);
            if (expected_tris.size() == 0) begin
                $error("triangle with no request waiting: %p", got);
                mismatches++;
            end else begin
                want = expected_tris.pop_front();
                compare_field("vertex_a_x", want.a_x, got.a_x);
                compare_field("vertex_a_y", want.a_y, got.a_y);
                compare_field("vertex_a_z", want.a_z, got.a_z);
                compare_field("vertex_b_x", want.b_x, got.b_x);
                compare_field("vertex_b_y", want.b_y, got.b_y);
                compare_field("vertex_b_z", want.b_z, got.b_z);
                compare_field("vertex_c_x", want.c_x, got.c_x);
                compare_field("vertex_c_y", want.c_y, got.c_y);
                compare_field("vertex_c_z", want.c_z, got.c_z);
                compare_field("lower_triangle", want.lower, got.lower);
                compare_field("last_of_cell", want.last, got.last);
            end
        end
    end

    always @(posedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 11);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input probe_t p);
        tri_t tris [2];
        int   n;
        if (!calm && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_altitude <= p.alt;
        do @(posedge aclk); while (s_ready !== 1'b1);
        advance_grid(p.alt, n, tris);
        if (p.typed) begin
            n = p.count;
            tris[0] = p.first;
            tris[1] = p.second;
        end
        for (int i = 0; i < n; i++) expected_tris = {expected_tris, tris[i]};
    endtask

    // Samples that close no cell leave nothing to wait for, so a settling wait follows the drain.
    task automatic settle_idle();
        while (expected_tris.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        apply_reg(idx, data);
    endtask

    task automatic run_grid(input grid_setup_t g, input bit hold_midway);
        probe_t p;
        s_valid <= 1'b0;
        settle_idle();
        write_reg(REG_ORIGIN_X, g.org_x);
        write_reg(REG_ORIGIN_Y, g.org_y);
        write_reg(REG_STEP_X, CFG_DATA_BITS'(g.spc_x));
        write_reg(REG_STEP_Y, CFG_DATA_BITS'(g.spc_y));
        write_reg(REG_GRID_WIDTH, CFG_DATA_BITS'(g.cols));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'(g.rows));
        write_reg(REG_NODATA, CFG_DATA_BITS'(g.missing));
        if (g.probe_unused) write_reg(REG_UNUSED, random_coord());
        cfg_wr_en <= 1'b0;
        calm = g.calm;
        p.typed = 1'b0;
        for (int k = 0; k < g.items; k++) begin
            if (hold_midway && k == g.items / 2) begin
                s_valid <= 1'b0;
                settle_idle();
            end
            p.alt = pick_altitude();
            send_sample(p);
        end
        calm = 1'b0;
    endtask

    initial begin
        int random_count;
        reset_mirror();

        // Reset geometry: 2 x 2 grid, unit Q8 spacing, top row at y = 256.
        add_probe('{32'h0000_0000, 1'b1, 0, '0, '0});
        add_probe('{32'h7FFF_FFFF, 1'b1, 0, '0, '0});
        add_probe('{32'h8000_0000, 1'b1, 0, '0, '0});
        add_probe('{32'hFFFF_FFFF, 1'b1, 2,
            make_tri('0, Q8_ONE, 32'h0000_0000, '0, '0, 32'h8000_0000,
                     Q8_ONE, Q8_ONE, 32'h7FFF_FFFF, 1'b0, 1'b0),
            make_tri(Q8_ONE, Q8_ONE, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000,
                     Q8_ONE, '0, 32'hFFFF_FFFF, 1'b1, 1'b1)});
        // Second grid after wrap: missing upper-left drops the first triangle.
        add_probe('{NODATA_RESET, 1'b1, 0, '0, '0});
        add_probe('{32'd5, 1'b1, 0, '0, '0});
        add_probe('{32'd7, 1'b1, 0, '0, '0});
        add_probe('{32'd9, 1'b1, 1,
            make_tri(Q8_ONE, Q8_ONE, 32'd5, '0, '0, 32'd7, Q8_ONE, '0, 32'd9, 1'b1, 1'b1),
            '0});
        // Missing lower-right drops the second triangle.
        add_probe('{32'd1, 1'b1, 0, '0, '0});
        add_probe('{32'd2, 1'b1, 0, '0, '0});
        add_probe('{32'd3, 1'b1, 0, '0, '0});
        add_probe('{NODATA_RESET, 1'b1, 1,
            make_tri('0, Q8_ONE, 32'd1, '0, '0, 32'd3, Q8_ONE, Q8_ONE, 32'd2, 1'b0, 1'b1),
            '0});
        // Missing lower-left is shared by both triangles.
        add_probe('{32'd1, 1'b1, 0, '0, '0});
        add_probe('{32'd2, 1'b1, 0, '0, '0});
        add_probe('{NODATA_RESET, 1'b1, 0, '0, '0});
        add_probe('{32'd4, 1'b1, 0, '0, '0});
        add_probe('{32'h1234_5678, 1'b0, 0, '0, '0});
        add_probe('{32'hEDCB_A987, 1'b0, 0, '0, '0});

        // Coordinate wrap, range clamps, zero steps, an unused index and a width
        // beyond the line buffer.
        add_setup('{40'h7F_FFFF_FF00, 40'h80_0000_0000, 24'hFF_FFFF, 24'hFF_FFFF,
                    13'd3, 16'hFFFF, 32'h7FFF_FFFF, 200, 1'b1, 1'b0});
        add_setup('{40'h80_0000_0000, 40'h7F_FFFF_FFFF, 24'd0, 24'd0,
                    13'd0, 16'd0, 32'h8000_0000, 30, 1'b0, 1'b0});
        add_setup('{40'h00_0000_0000, 40'h00_0000_0000, 24'd1, 24'd1,
                    13'd1, 16'd1, 32'h0000_0000, 30, 1'b0, 1'b1});
        add_setup('{40'h00_0000_1000, 40'hFF_FFFF_F000, 24'd256, 24'd256,
                    13'h1FFF, 16'd2, NODATA_RESET, 300, 1'b1, 1'b0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) send_sample(probes[i]);
        foreach (fixed[i]) run_grid(fixed[i], 1'b0);

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            grid_setup_t g;
            g = random_setup();
            run_grid(g, random_count == 0);
            random_count += g.items;
        end

        s_valid <= 1'b0;
        settle_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ght_pkg.sv
rtl/ght_ram.sv
rtl/grid_heightmap_triangulator.sv
dv/grid_heightmap_triangulator_test.sv
